// File: hw/rtl/sslpt_pkg.sv
// sslpt_pkg: shared types and constants for the sorted slope table block
// request kinds, result status codes and default table depth
// no dependencies
package sslpt_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int SLOPE_W         = 32;
    localparam int REQ_W           = 2;
    localparam int STAT_W          = 2;
    localparam int IN_DATA_W       = 4 * SLOPE_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE = 2'd0,
        STAT_FULL = 2'd1,
        STAT_NO   = 2'd2,
        STAT_YES  = 2'd3
    } stat_t;

    // unsigned magnitude of a signed 32-bit value
    function automatic logic [SLOPE_W-1:0] mag32(input logic [SLOPE_W-1:0] v);
        logic [SLOPE_W-1:0] r;
        r = v[SLOPE_W-1] ? (~v + SLOPE_W'(1)) : v;
        return r;
    endfunction

endpackage

// File: hw/rtl/sorted_slope_table_line_parabola_test.sv
// sorted_slope_table_line_parabola_test: sorted slope table with parabola query
// one memory, one shared 32x32 multiplier and a small sequencer
// depends on sslpt_pkg
//
// usage
//   input stream s_*: one beat is one request; s_tuser carries the request kind
//   (clear, insert, query), s_tdata carries slope_in and the parabola a, b, c
//   output stream m_*: exactly one beat per request; m_tuser carries the status,
//   m_tdata the chosen slope (zero unless the status is yes)
// timing: the result beat goes valid in the same cycle that the next request
// can be taken; each request runs its steps as below
//   clear, the unused kind, a full-table insert and an empty-table query go
//   straight to the response; insert moves each larger stored slope up one
//   place, then writes the new slope; query forms |a|*|c|, scans for the
//   first slope not below b, tests it and, if it fails and does not sit at
//   index 0, the slope before it; when b is above every slope only the last
//   slope is tested
// flow control
//   s_tready is high only while the sequencer is idle; one request at a time
//   a new result waits for the output register to drain when m_tready is low
// reset
//   rst_n clears the sequencer, the entry count and the output valid; the
//   memory itself is not cleared, only entries below the count are ever read
module sorted_slope_table_line_parabola_test
    import sslpt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // slope_in [31:0], coef_a [63:32], coef_b [95:64], coef_c [127:96]
    input  logic [IN_DATA_W-1:0] s_tdata,
    // req_type [1:0]
    input  logic [REQ_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // chosen_slope [31:0]
    output logic [SLOPE_W-1:0]   m_tdata,
    // status [1:0]
    output logic [STAT_W-1:0]    m_tuser
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int PROD_W = 2 * SLOPE_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MULP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SQ,
        S_TEST,
        S_LOAD2,
        S_INS_RD,
        S_INS_CMP,
        S_INS_WR,
        S_RESP
    } state_t;

    state_t                     state_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [ADDR_W-1:0]          idx_reg;      // scan index, also insert position
    logic signed [SLOPE_W-1:0]  key_reg;      // slope_in or coef_b
    logic [SLOPE_W-1:0]         a_reg;
    logic [SLOPE_W-1:0]         c_reg;
    logic signed [SLOPE_W-1:0]  k_reg;        // candidate slope
    logic                       second_reg;   // predecessor still to test
    logic                       ok_reg;       // a and c share a nonzero sign
    logic [PROD_W-1:0]          p_reg;        // |a|*|c|
    logic [PROD_W-1:0]          sq_reg;       // (b-k)^2
    stat_t                      res_stat_reg;
    logic [SLOPE_W-1:0]         res_slope_reg;
    logic                       m_tvalid_reg;
    logic [SLOPE_W-1:0]         m_tdata_reg;
    logic [STAT_W-1:0]          m_tuser_reg;

    // slope memory, one write and one registered read per cycle
    logic [SLOPE_W-1:0]         mem [TABLE_DEPTH];
    logic signed [SLOPE_W-1:0]  rdata_reg;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       wr_en;
    logic [SLOPE_W-1:0]         wr_data;

    // shared multiplier
    logic [SLOPE_W-1:0]         mul_x;
    logic [SLOPE_W-1:0]         mul_y;
    logic [PROD_W-1:0]          mul_prod;
    logic signed [SLOPE_W:0]    diff;
    logic [SLOPE_W:0]           diff_mag;
    logic                       pass;
    logic                       rd_lt_key;
    logic                       scan_last;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign diff     = {key_reg[SLOPE_W-1], key_reg} - {k_reg[SLOPE_W-1], k_reg};
    assign diff_mag = diff[SLOPE_W] ? (~diff + (SLOPE_W+1)'(1)) : diff;

    always_comb
    begin
        if (state_reg == S_MULP)
        begin
            mul_x = mag32(a_reg);
            mul_y = mag32(c_reg);
        end
        else
        begin
            mul_x = diff_mag[SLOPE_W-1:0];
            mul_y = diff_mag[SLOPE_W-1:0];
        end
    end

    assign mul_prod = PROD_W'(mul_x) * PROD_W'(mul_y);

    // 4p is at least 2^64 once p reaches 2^62, above every square
    assign pass = ok_reg &&
                  ((p_reg[PROD_W-1:PROD_W-2] != 2'b00) ||
                   (sq_reg < {p_reg[PROD_W-3:0], 2'b00}));

    assign rd_lt_key = (rdata_reg < key_reg);
    assign scan_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        rd_addr = idx_reg;
        wr_en   = 1'b0;
        wr_data = key_reg;
        case (state_reg)
            S_INS_RD:  rd_addr = idx_reg - ADDR_W'(1);
            S_TEST:    rd_addr = idx_reg - ADDR_W'(1);
            S_INS_CMP:
            begin
                wr_en   = 1'b1;
                wr_data = (rdata_reg > key_reg) ? rdata_reg : key_reg;
            end
            S_INS_WR:  wr_en = 1'b1;
            default:   rd_addr = idx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[idx_reg] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            key_reg       <= '0;
            a_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            second_reg    <= 1'b0;
            ok_reg        <= 1'b0;
            p_reg         <= '0;
            sq_reg        <= '0;
            res_stat_reg  <= STAT_DONE;
            res_slope_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= '0;
        end
        else
        begin
            // the response state loads the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != S_RESP))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        res_stat_reg  <= STAT_DONE;
                        res_slope_reg <= '0;
                        a_reg         <= s_tdata[2*SLOPE_W-1:SLOPE_W];
                        c_reg         <= s_tdata[4*SLOPE_W-1:3*SLOPE_W];
                        unique case (req_t'(s_tuser))
                            REQ_CLEAR:
                            begin
                                count_reg <= '0;
                                state_reg <= S_RESP;
                            end
                            REQ_INSERT:
                            begin
                                key_reg <= s_tdata[SLOPE_W-1:0];
                                idx_reg <= count_reg[ADDR_W-1:0];
                                if (count_reg == CNT_W'(TABLE_DEPTH))
                                begin
                                    res_stat_reg <= STAT_FULL;
                                    state_reg    <= S_RESP;
                                end
                                else if (count_reg == '0)
                                begin
                                    state_reg <= S_INS_WR;
                                end
                                else
                                begin
                                    state_reg <= S_INS_RD;
                                end
                            end
                            REQ_QUERY:
                            begin
                                key_reg      <= s_tdata[3*SLOPE_W-1:2*SLOPE_W];
                                idx_reg      <= '0;
                                res_stat_reg <= STAT_NO;
                                state_reg    <= (count_reg == '0) ? S_RESP : S_MULP;
                            end
                            REQ_NONE:
                            begin
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end
                S_MULP:
                begin
                    p_reg     <= mul_prod;
                    ok_reg    <= (a_reg != '0) && (c_reg != '0) &&
                                 (a_reg[SLOPE_W-1] == c_reg[SLOPE_W-1]);
                    state_reg <= S_SCAN_RD;
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CMP;
                end
                S_SCAN_CMP:
                begin
                    // lower bound: first slope not below the key
                    if (rd_lt_key && !scan_last)
                    begin
                        idx_reg   <= idx_reg + ADDR_W'(1);
                        state_reg <= S_SCAN_RD;
                    end
                    else
                    begin
                        k_reg      <= rdata_reg;
                        second_reg <= !rd_lt_key && (idx_reg != '0);
                        state_reg  <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    sq_reg    <= mul_prod;
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    if (pass)
                    begin
                        res_stat_reg  <= STAT_YES;
                        res_slope_reg <= k_reg;
                        state_reg     <= S_RESP;
                    end
                    else if (second_reg)
                    begin
                        second_reg <= 1'b0;
                        state_reg  <= S_LOAD2;
                    end
                    else
                    begin
                        state_reg <= S_RESP;
                    end
                end
                S_LOAD2:
                begin
                    k_reg     <= rdata_reg;
                    state_reg <= S_SQ;
                end
                S_INS_RD:
                begin
                    state_reg <= S_INS_CMP;
                end
                S_INS_CMP:
                begin
                    // larger neighbour moves up one place, else the slope lands here
                    if (rdata_reg > key_reg)
                    begin
                        idx_reg   <= idx_reg - ADDR_W'(1);
                        state_reg <= (idx_reg == ADDR_W'(1)) ? S_INS_WR : S_INS_RD;
                    end
                    else
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        state_reg <= S_RESP;
                    end
                end
                S_INS_WR:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_slope_reg;
                        m_tuser_reg  <= res_stat_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_slope_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != STAT_YES)) |-> (m_tdata == '0))
        else $error("chosen slope nonzero without a yes status");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty the table");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new request taken before the result was formed");

    a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_INSERT) &&
         (count_reg == CNT_W'(TABLE_DEPTH))) |=> (count_reg == CNT_W'(TABLE_DEPTH)))
        else $error("insert into a full table changed the count");

endmodule
